/* hw/rtl/ohr_pkg.sv */
// Package for the overwriting history ring.
// Holds default sizes, field widths and command codes; no dependencies.
package ohr_pkg;

	localparam int unsigned DEPTH_DEF    = 4096;
	localparam int unsigned MAX_READ_DEF = 64;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CURSOR_W = 64;
	localparam int unsigned LEN_W    = 7;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_READ  = 1'b1
	} cmd_t;

endpackage

/* hw/rtl/overwriting_history_ring.sv */
// Overwriting history ring: keeps the newest DEPTH bytes in one RAM plus a 64-bit write count.
// Write transfer: a new write can be taken every cycle while no read is in progress.
// Read transfer: cursor setup (snap, count, address, issue), then the bytes one by one; each
// byte is read from the RAM with registered data, then held in the output register, and the
// next byte's read is issued when the current byte transfers. An empty read skips the address
// and issue steps. No input is taken until the last result transfers.
// Reset (arst_n low) clears the write count and control; RAM contents stay undefined.
module overwriting_history_ring
	import ohr_pkg::*;
#(
	parameter int unsigned DEPTH    = DEPTH_DEF,
	parameter int unsigned MAX_READ = MAX_READ_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [BYTE_W-1:0]   data_byte,
	input  logic [CURSOR_W-1:0] read_cursor,
	input  logic [LEN_W-1:0]    max_len,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [BYTE_W-1:0]   out_byte,
	output logic                has_data,
	output logic [CURSOR_W-1:0] next_cursor,
	output logic                last
);

	localparam int unsigned AW = $clog2(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SNAP,
		S_COUNT,
		S_ADDR,
		S_ISSUE,
		S_FETCH,
		S_SEND
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       wr_ptr_q;
	logic [CURSOR_W-1:0] total_q;
	logic [CURSOR_W-1:0] cur_q;
	logic [LEN_W-1:0]    limit_q;
	logic [LEN_W-1:0]    cnt_q;
	logic [AW:0]         dist_q;
	logic [AW-1:0]       rd_ptr_q;

	logic                wr_fire;
	logic                rd_en;
	logic [BYTE_W-1:0]   rd_data;
	logic [LEN_W-1:0]    len_clamp;
	logic [CURSOR_W-1:0] base;
	logic [CURSOR_W-1:0] diff;
	logic [AW:0]         wr_ext;
	logic [AW-1:0]       start_addr;
	logic [AW-1:0]       rd_ptr_inc;

	assign in_ready = (state_q == S_IDLE);
	assign wr_fire  = in_valid && in_ready && (cmd == CMD_WRITE);
	assign rd_en    = (state_q == S_ISSUE) ||
	                  ((state_q == S_SEND) && out_ready && !last);

	assign len_clamp = (max_len > LEN_W'(MAX_READ)) ? LEN_W'(MAX_READ) : max_len;
	assign base      = total_q - CURSOR_W'(DEPTH);
	assign diff      = total_q - cur_q;
	assign wr_ext    = {1'b0, wr_ptr_q};

	// Step back from the write pointer by the distance, wrapping around the ring.
	always_comb begin
		if (dist_q > wr_ext) begin
			start_addr = AW'(wr_ext + (AW+1)'(DEPTH) - dist_q);
		end else begin
			start_addr = AW'(wr_ext - dist_q);
		end
	end

	assign rd_ptr_inc = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;

	ohr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_fire),
		.waddr(wr_ptr_q),
		.wdata(data_byte),
		.re   (rd_en),
		.raddr(rd_ptr_q),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wr_ptr_q    <= '0;
			total_q     <= '0;
			out_valid   <= 1'b0;
			cur_q       <= '0;
			limit_q     <= '0;
			cnt_q       <= '0;
			dist_q      <= '0;
			rd_ptr_q    <= '0;
			out_byte    <= '0;
			has_data    <= 1'b0;
			next_cursor <= '0;
			last        <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (cmd == CMD_WRITE) begin
							wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
							total_q  <= total_q + 1'b1;
						end else begin
							cur_q   <= read_cursor;
							limit_q <= len_clamp;
							state_q <= S_SNAP;
						end
					end
				end
				S_SNAP: begin
					// Move a lapped cursor up to the oldest byte still held.
					if (total_q > CURSOR_W'(DEPTH) && cur_q < base) begin
						cur_q <= base;
					end
					state_q <= S_COUNT;
				end
				S_COUNT: begin
					if (cur_q < total_q && limit_q != '0) begin
						cnt_q   <= (diff < CURSOR_W'(limit_q)) ? LEN_W'(diff) : limit_q;
						dist_q  <= (AW+1)'(diff);
						state_q <= S_ADDR;
					end else begin
						out_byte    <= '0;
						has_data    <= 1'b0;
						next_cursor <= cur_q;
						last        <= 1'b1;
						out_valid   <= 1'b1;
						state_q     <= S_SEND;
					end
				end
				S_ADDR: begin
					rd_ptr_q <= start_addr;
					state_q  <= S_ISSUE;
				end
				S_ISSUE: begin
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					out_byte    <= rd_data;
					has_data    <= 1'b1;
					next_cursor <= cur_q + 1'b1;
					last        <= (cnt_q == LEN_W'(1));
					out_valid   <= 1'b1;
					cur_q       <= cur_q + 1'b1;
					cnt_q       <= cnt_q - 1'b1;
					rd_ptr_q    <= rd_ptr_inc;
					state_q     <= S_SEND;
				end
				S_SEND: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						// The next byte's read was issued along with this transfer.
						state_q   <= last ? S_IDLE : S_FETCH;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/ohr_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ohr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* tb/overwriting_history_ring_tb.sv */
// Testbench for overwriting_history_ring: directed and random write/read traffic
// with random idling on both sides, checked against an in-bench mirror of the ring.
// Depends on ohr_pkg and the overwriting_history_ring RTL.
module overwriting_history_ring_tb;
	import ohr_pkg::*;

	localparam int unsigned RING_DEPTH = DEPTH_DEF;
	localparam int unsigned READ_CAP   = MAX_READ_DEF;

	typedef struct packed {
		logic [BYTE_W-1:0]   out_byte;
		logic                has_data;
		logic [CURSOR_W-1:0] next_cursor;
		logic                last;
	} read_beat_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid;
	logic                in_ready;
	cmd_t                cmd;
	logic [BYTE_W-1:0]   data_byte;
	logic [CURSOR_W-1:0] read_cursor;
	logic [LEN_W-1:0]    max_len;
	logic                out_valid;
	logic                out_ready;
	logic [BYTE_W-1:0]   out_byte;
	logic                has_data;
	logic [CURSOR_W-1:0] next_cursor;
	logic                last;

	// mirror of the ring contents and write count, updated on each input transfer
	logic [BYTE_W-1:0]   mirror_ring [RING_DEPTH];
	logic [CURSOR_W-1:0] mirror_count = '0;
	read_beat_t          expected_beats [$];

	int mismatches = 0;
	int in_gap_max = 0;
	int out_gap_max = 0;
	int sink_hold = 0;

	always #1 clk = ~clk;

	overwriting_history_ring #(
		.DEPTH    (RING_DEPTH),
		.MAX_READ (READ_CAP)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.read_cursor (read_cursor),
		.max_len     (max_len),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.has_data    (has_data),
		.next_cursor (next_cursor),
		.last        (last)
	);

	function automatic void mirror_item(cmd_t c, logic [BYTE_W-1:0] b,
			logic [CURSOR_W-1:0] cur, logic [LEN_W-1:0] len);
		logic [CURSOR_W-1:0] lim;
		logic [CURSOR_W-1:0] avail;
		logic [CURSOR_W-1:0] n_bytes;
		logic [CURSOR_W-1:0] pos;
		read_beat_t beat;
		if (c == CMD_WRITE) begin
			mirror_ring[mirror_count % RING_DEPTH] = b;
			mirror_count = mirror_count + 1;
		end else begin
			lim = (len > READ_CAP) ? CURSOR_W'(READ_CAP) : CURSOR_W'(len);
			// snap a lapped reader to the oldest byte still held
			if (mirror_count > RING_DEPTH && cur < mirror_count - RING_DEPTH)
				cur = mirror_count - RING_DEPTH;
			avail = (cur < mirror_count) ? mirror_count - cur : '0;
			n_bytes = (avail < lim) ? avail : lim;
			if (n_bytes == 0) begin
				beat = '{out_byte: '0, has_data: 1'b0, next_cursor: cur, last: 1'b1};
				expected_beats.push_back(beat);
			end else begin
				for (logic [CURSOR_W-1:0] k = 0; k < n_bytes; k++) begin
					pos = cur + k;
					beat.out_byte    = mirror_ring[pos % RING_DEPTH];
					beat.has_data    = 1'b1;
					beat.next_cursor = pos + 1;
					beat.last        = (k + 1 == n_bytes);
					expected_beats.push_back(beat);
				end
			end
		end
	endfunction

	// called at a rising edge; returns at the rising edge of the transfer
	task automatic send_item(cmd_t c, logic [BYTE_W-1:0] b, logic [CURSOR_W-1:0] cur,
			logic [LEN_W-1:0] len);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= c;
		data_byte   <= b;
		read_cursor <= cur;
		max_len     <= len;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		mirror_item(c, b, cur, len);
	endtask

	task automatic write_byte(logic [BYTE_W-1:0] b);
		send_item(CMD_WRITE, b, {$urandom, $urandom}, LEN_W'($urandom));
	endtask

	task automatic read_from(logic [CURSOR_W-1:0] cur, logic [LEN_W-1:0] len);
		send_item(CMD_READ, BYTE_W'($urandom), cur, len);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_beats.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic void compare_field(string field, logic [63:0] got, logic [63:0] want);
		if (got !== want) begin
			if (mismatches < 50)
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	task automatic check_beat();
		read_beat_t want;
		if (expected_beats.size() == 0) begin
			if (mismatches < 50)
				$display("%0t: unexpected result: expected none, actual byte=%0h has_data=%b cursor=%0h last=%b",
					$time, out_byte, has_data, next_cursor, last);
			mismatches++;
		end else begin
			want = expected_beats.pop_front();
			compare_field("out_byte", out_byte, want.out_byte);
			compare_field("has_data", has_data, want.has_data);
			compare_field("next_cursor", next_cursor, want.next_cursor);
			compare_field("last", last, want.last);
		end
	endtask

	initial begin : result_sink
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				stall = sink_hold;
				sink_hold = 0;
			end else begin
				stall = $urandom_range(0, out_gap_max);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			check_beat();
		end
	end

	// nothing written yet: every read comes back empty
	task automatic test_empty_history();
		in_gap_max = 18;
		out_gap_max = 18;
		read_from('0, 7'd1);
		read_from('0, '0);
		read_from('1, 7'd64);
		read_from(64'd1, 7'd127);
		drain_results();
	endtask

	task automatic test_directed_reads();
		write_byte(8'h00);
		write_byte(8'hFF);
		write_byte(8'hA5);
		write_byte(8'h5A);
		write_byte(8'h01);
		write_byte(8'h80);
		read_from('0, 7'd127);
		read_from(64'd2, 7'd1);
		read_from(64'd5, 7'd64);
		read_from(64'd6, 7'd10);
		read_from(64'd7, 7'd3);
		read_from(64'd3, '0);
		read_from('0, 7'd64);
		read_from(64'h8000_0000_0000_0000, 7'd64);
		drain_results();
	endtask

	task automatic test_lapped_reader();
		logic [CURSOR_W-1:0] base;
		in_gap_max = 0;
		out_gap_max = 0;
		repeat (RING_DEPTH + 200) write_byte(BYTE_W'($urandom));
		in_gap_max = 18;
		out_gap_max = 18;
		base = mirror_count - RING_DEPTH;
		read_from('0, 7'd64);
		read_from(base - 1, 7'd5);
		read_from(base, 7'd64);
		read_from(base + 1, 7'd3);
		// straddle the point where the store index wraps to zero
		read_from(64'(RING_DEPTH) - 3, 7'd6);
		read_from(mirror_count - 1, 7'd64);
		read_from(mirror_count, 7'd1);
		drain_results();
	endtask

	// hold the result side off during a long read while writes wait behind it
	task automatic test_output_stall();
		in_gap_max = 0;
		out_gap_max = 0;
		sink_hold = 300;
		read_from(mirror_count - 64, 7'd64);
		repeat (30) write_byte(BYTE_W'($urandom));
		read_from(mirror_count - 10, 7'd20);
		repeat (10) write_byte(BYTE_W'($urandom));
		drain_results();
	endtask

	task automatic test_random_traffic();
		int sent;
		int pick;
		int back;
		logic [CURSOR_W-1:0] base;
		logic [CURSOR_W-1:0] cur;
		logic [LEN_W-1:0] len;
		sent = 0;
		while (sent < 200) begin
			if (sent % 25 == 0) begin
				in_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
				out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
			end
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				write_byte(BYTE_W'($urandom));
			end else begin
				base = (mirror_count > RING_DEPTH) ? mirror_count - RING_DEPTH : '0;
				pick = $urandom_range(0, 9);
				if (pick <= 5) begin
					back = $urandom_range(0, 100);
					cur = (back > mirror_count) ? '0 : mirror_count - back;
				end else if (pick == 6) begin
					cur = base + $urandom_range(0, RING_DEPTH);
				end else if (pick == 7) begin
					cur = (base > 1) ? {$urandom, $urandom} % base : '0;
				end else if (pick == 8) begin
					cur = mirror_count + 1 + $urandom_range(0, 1000);
				end else begin
					cur = {$urandom, $urandom};
				end
				len = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(0, 127))
					: LEN_W'($urandom_range(1, 64));
				read_from(cur, len);
			end
			sent++;
		end
		drain_results();
	endtask

	initial begin : run_limit
		#5_000_000;
		$display("timeout waiting for transfers");
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : main_sequence
		in_valid    = 1'b0;
		cmd         = CMD_WRITE;
		data_byte   = '0;
		read_cursor = '0;
		max_len     = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		test_empty_history();
		test_directed_reads();
		test_lapped_reader();
		test_output_stall();
		test_random_traffic();
		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_beats.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
